@@ sv/mird_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mird_pkg: shared types and constants for the radix digit converter
// Field widths, radix limits and the control group that the top level
// drives into every digit cell of the row.
// ----------------------------------------------------------------------------
package mird_pkg;

  localparam int VALUE_W  = 64;
  localparam int BYTES_W  = 4;
  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // Control shared by all cells of the row
  typedef struct packed {
    logic               clear;  // zero digit, carry and step flag
    logic               shift;  // take the digit of the lower neighbor
    logic [RADIX_W-1:0] radix;  // number base, 8..16
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/mird_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mird_in_if: input channel of the radix digit converter
// Valid/ready handshake carrying one value to convert.
// ----------------------------------------------------------------------------
interface mird_in_if;

  logic                            valid;
  logic                            ready;
  logic [mird_pkg::VALUE_W-1:0]    value;
  logic [mird_pkg::BYTES_W-1:0]    byte_size;
  logic                            is_signed;
  logic [mird_pkg::RADIX_W-1:0]    radix;

  modport source (output valid, value, byte_size, is_signed, radix, input ready);
  modport sink   (input valid, value, byte_size, is_signed, radix, output ready);

endinterface

`default_nettype wire

@@ sv/mird_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mird_out_if: output channel of the radix digit converter
// Valid/ready handshake carrying one sign marker or one digit per word.
// ----------------------------------------------------------------------------
interface mird_out_if;

  logic                            valid;
  logic                            ready;
  logic                            is_minus;
  logic [mird_pkg::DIGIT_W-1:0]    digit;
  logic                            last;

  modport source (output valid, is_minus, digit, last, input ready);
  modport sink   (input valid, is_minus, digit, last, output ready);

endinterface

`default_nettype wire

@@ sv/mird_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mird_cell: one digit cell of the conversion row
// Holds one radix digit. On a step it doubles the digit, adds the carry of
// its lower neighbor and reduces modulo the radix; carry and step flag are
// registered and passed up the row in the next cycle.
// ----------------------------------------------------------------------------
module mird_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mird_pkg::cell_ctl_t           ctl,
  input  wire logic                          step_in,
  input  wire logic                          carry_in,
  input  wire logic [mird_pkg::DIGIT_W-1:0]  digit_in,
  output logic                               step_out,
  output logic                               carry_out,
  output logic [mird_pkg::DIGIT_W-1:0]       digit
);

  logic [mird_pkg::DIGIT_W:0] dbl;
  logic                       wrap;

  // 2*d + cin, fits in 5 bits
  assign dbl  = {digit, carry_in};
  assign wrap = (dbl >= ctl.radix);

  // step flag is control state
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      step_out <= 1'b0;
    end else begin
      step_out <= step_in;
    end
  end

  // digit and carry
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit     <= '0;
      carry_out <= 1'b0;
    end else if (ctl.shift) begin
      digit <= digit_in;
    end else if (step_in) begin
      if (wrap) begin
        digit     <= mird_pkg::DIGIT_W'(dbl - ctl.radix);
        carry_out <= 1'b1;
      end else begin
        digit     <= dbl[mird_pkg::DIGIT_W-1:0];
        carry_out <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/masked_integer_radix_digits.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_integer_radix_digits: integer to radix digit converter
// Masks a value to its operand size, strips the sign if asked and emits
// the digits in radix 8..16, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one word per value (value, byte_size, is_signed, radix). Taken
//         only while no conversion is running.
//   out : one word per result. A negative signed value first gives a word
//         with is_minus set, then its magnitude digits; the final digit has
//         last set. Zero gives a single zero digit.
// Flow (W = 8*MAX_BYTES, N = ceil(W/3) digit cells, 64 and 22 by default):
//   The W-bit magnitude is fed bit serially, MSB first, into a row of N digit
//   cells; the step ripples up the row one cell per cycle. Leading zeros are
//   then shifted out at one per cycle and the digits leave one per cycle
//   while out is ready. A new value is accepted only after the last digit
//   word is loaded.
// Stall: a stalled receiver holds the output register and the digit row
//   while digits are emitted; nothing is dropped. The last word may wait in
//   the output register while the next value is accepted.
// Reset: rst (synchronous) returns to idle and empties the output register.
// ----------------------------------------------------------------------------
module masked_integer_radix_digits #(
  parameter int MAX_BYTES = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mird_in_if.sink    in,
  mird_out_if.source out
);

  localparam int W      = 8 * MAX_BYTES;
  localparam int NCELLS = (W + 2) / 3;
  localparam int CNT_W  = $clog2(W + NCELLS);
  localparam int REM_W  = $clog2(NCELLS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_SIGN, S_SKIP, S_EMIT
  } state_t;

  state_t                          state;
  logic [W-1:0]                    shreg;
  logic                            neg;
  logic [mird_pkg::RADIX_W-1:0]    radix_q;
  logic [CNT_W-1:0]                cnt;
  logic [REM_W-1:0]                rem;

  logic [mird_pkg::BYTES_W-1:0]    bytes_sat;
  logic [mird_pkg::RADIX_W-1:0]    radix_sat;
  logic [W-1:0]                    mask;
  logic [W-1:0]                    masked;
  logic                            top_bit;
  logic                            neg_in;
  logic [W-1:0]                    mag_in;

  logic                            load_ok;
  logic                            out_load;
  logic                            feed;
  logic                            shift_en;
  mird_pkg::cell_ctl_t             ctl;

  logic                            c_step  [NCELLS];
  logic                            c_carry [NCELLS];
  logic [mird_pkg::DIGIT_W-1:0]    c_dig   [NCELLS];
  logic [mird_pkg::DIGIT_W-1:0]    dig_top;

  // operand size and radix saturation
  always_comb begin
    bytes_sat = in.byte_size;
    if (bytes_sat == '0) begin
      bytes_sat = mird_pkg::BYTES_W'(1);
    end else if (bytes_sat > mird_pkg::BYTES_W'(MAX_BYTES)) begin
      bytes_sat = mird_pkg::BYTES_W'(MAX_BYTES);
    end
    radix_sat = in.radix;
    if (radix_sat < mird_pkg::RADIX_MIN) begin
      radix_sat = mird_pkg::RADIX_MIN;
    end else if (radix_sat > mird_pkg::RADIX_MAX) begin
      radix_sat = mird_pkg::RADIX_MAX;
    end
  end

  // byte mask, sign bit and magnitude
  always_comb begin
    mask    = '0;
    top_bit = 1'b0;
    for (int j = 0; j < MAX_BYTES; j++) begin
      if (mird_pkg::BYTES_W'(j) < bytes_sat) begin
        mask[8*j +: 8] = 8'hFF;
      end
      if (mird_pkg::BYTES_W'(j + 1) == bytes_sat) begin
        top_bit = in.value[8*j + 7];
      end
    end
    masked = in.value[W-1:0] & mask;
    neg_in = in.is_signed & top_bit;
    mag_in = neg_in ? ((~masked + W'(1)) & mask) : masked;
  end

  assign in.ready = (state == S_IDLE);
  assign load_ok  = !out.valid || out.ready;
  assign out_load = load_ok && ((state == S_SIGN) || (state == S_EMIT));
  assign feed     = (state == S_CONV) && (cnt < CNT_W'(W));
  assign dig_top  = c_dig[NCELLS-1];
  assign shift_en = ((state == S_SKIP) && (dig_top == '0) && (rem > REM_W'(1)))
                 || ((state == S_EMIT) && load_ok);

  assign ctl.clear = in.valid && in.ready;
  assign ctl.shift = shift_en;
  assign ctl.radix = radix_q;

  // row of digit cells, least significant at index 0
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      mird_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .step_in   (feed),
        .carry_in  (shreg[W-1]),
        .digit_in  ('0),
        .step_out  (c_step[i]),
        .carry_out (c_carry[i]),
        .digit     (c_dig[i])
      );
    end else begin : g_next
      mird_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .step_in   (c_step[i-1]),
        .carry_in  (c_carry[i-1]),
        .digit_in  (c_dig[i-1]),
        .step_out  (c_step[i]),
        .carry_out (c_carry[i]),
        .digit     (c_dig[i])
      );
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out.valid <= 1'b0;
    end else begin
      // valid set on a load, dropped once the word is taken
      if (out_load) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            shreg   <= mag_in;
            neg     <= neg_in;
            radix_q <= radix_sat;
            cnt     <= '0;
            rem     <= REM_W'(NCELLS);
            state   <= S_CONV;
          end
        end
        S_CONV: begin
          if (feed) begin
            shreg <= shreg << 1;
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(W + NCELLS - 2)) begin
            state <= neg ? S_SIGN : S_SKIP;
          end
        end
        S_SIGN: begin
          if (load_ok) begin
            out.is_minus <= 1'b1;
            out.digit    <= '0;
            out.last     <= 1'b0;
            state        <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (shift_en) begin
            rem <= rem - REM_W'(1);
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            out.is_minus <= 1'b0;
            out.digit    <= dig_top;
            out.last     <= (rem == REM_W'(1));
            rem          <= rem - REM_W'(1);
            if (rem == REM_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
